### hw/rtl/hfs_pkg.sv
// Package with the types, constants and word formats of the hexamer frame score unit.
`default_nettype none
package hfs_pkg;

    localparam int TABLE_VALUE_WIDTH = 16;
    localparam int SUM_WIDTH         = 40;
    localparam int TABLE_ENTRIES     = 4096;
    localparam int ADDR_WIDTH        = $clog2(TABLE_ENTRIES);
    localparam int SCORE_WIDTH       = 40;
    localparam int SEEN_WIDTH        = 3;

    localparam logic [SEEN_WIDTH-1:0] HEXAMER_BASES = SEEN_WIDTH'(6);

    localparam logic MODE_TABLE = 1'b0;
    localparam logic MODE_BASE  = 1'b1;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_C = 8'h63;
    localparam logic [7:0] CHAR_G = 8'h67;
    localparam logic [7:0] CHAR_T = 8'h74;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    typedef logic signed [TABLE_VALUE_WIDTH-1:0] table_value_t;
    typedef logic signed [SUM_WIDTH-1:0]         sum_t;
    typedef logic [ADDR_WIDTH-1:0]               hexamer_index_t;
    typedef logic [1:0]                          phase_t;

    typedef struct packed {
        logic               mode;
        logic [11:0]        table_address;
        logic signed [15:0] table_value;
        logic [7:0]         base;
        logic               last;
    } hfs_in_t;

    typedef struct packed {
        logic signed [SCORE_WIDTH-1:0] window_score;
        logic                          saturated;
    } hfs_out_t;

    typedef struct packed {
        logic         valid;
        logic         add_en;
        logic         last;
        phase_t       phase;
        table_value_t value;
    } hfs_base_stage_t;

    typedef struct packed {
        logic valid;
        sum_t sum_0;
        sum_t sum_1;
        sum_t sum_2;
        logic overflow;
    } hfs_snapshot_t;

endpackage
`default_nettype wire

### hw/rtl/hfs_front.sv
// Base coding, hexamer index shift register, window counters and the log-ratio table.
`default_nettype none
module hfs_front
    import hfs_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_write_enable,
    input  wire logic            cfg_write_data,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire hfs_in_t         item,
    input  wire logic            stage_take,
    output hfs_base_stage_t      stage
);

    logic                  reverse_reg;
    hexamer_index_t        recent_reg;
    hexamer_index_t        recent_next;
    logic [SEEN_WIDTH-1:0] seen_reg;
    logic [SEEN_WIDTH-1:0] seen_next;
    phase_t                frame_reg;
    phase_t                phase_next;
    logic                  valid_reg;
    logic                  add_en_reg;
    logic                  last_reg;
    phase_t                phase_reg;
    table_value_t          rd_data_reg;
    logic [1:0]            code;
    logic                  accept;
    logic                  accept_base;
    logic                  accept_table;

    table_value_t table_mem [TABLE_ENTRIES];

    assign item_ready   = !valid_reg || stage_take;
    assign accept       = item_valid && item_ready;
    assign accept_base  = accept && (item.mode == MODE_BASE);
    assign accept_table = accept && (item.mode == MODE_TABLE);

    always_comb
    begin
        case (item.base)
            CHAR_A:  code = reverse_reg ? 2'd3 : 2'd0;
            CHAR_C:  code = reverse_reg ? 2'd2 : 2'd1;
            CHAR_G:  code = reverse_reg ? 2'd1 : 2'd2;
            CHAR_T:  code = reverse_reg ? 2'd0 : 2'd3;
            default: code = 2'd1;
        endcase
    end

    assign recent_next = {recent_reg[ADDR_WIDTH-3:0], code};
    assign seen_next   = (seen_reg == HEXAMER_BASES) ? seen_reg : seen_reg + 1'b1;
    assign phase_next  = (frame_reg == PHASE_2) ? PHASE_0 : frame_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg <= 1'b0;
            recent_reg  <= '0;
            seen_reg    <= '0;
            frame_reg   <= PHASE_0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                reverse_reg <= cfg_write_data;
            end
            if (accept_base)
            begin
                valid_reg <= 1'b1;
                if (item.last)
                begin
                    recent_reg <= '0;
                    seen_reg   <= '0;
                    frame_reg  <= PHASE_0;
                end
                else
                begin
                    recent_reg <= recent_next;
                    seen_reg   <= seen_next;
                    frame_reg  <= phase_next;
                end
            end
            else if (stage_take)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_base)
        begin
            add_en_reg <= (seen_next == HEXAMER_BASES);
            last_reg   <= item.last;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_table)
        begin
            table_mem[item.table_address[ADDR_WIDTH-1:0]] <= table_value_t'(item.table_value);
        end
        if (accept_base)
        begin
            rd_data_reg <= table_mem[recent_next];
        end
    end

    assign stage.valid  = valid_reg;
    assign stage.add_en = add_en_reg;
    assign stage.last   = last_reg;
    assign stage.phase  = phase_reg;
    assign stage.value  = rd_data_reg;

endmodule
`default_nettype wire

### hw/rtl/hfs_accum.sv
// Saturating phase sum accumulators and the end-of-window snapshot register.
`default_nettype none
module hfs_accum
    import hfs_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hfs_base_stage_t stage,
    output logic                 stage_take,
    input  wire logic            snap_take,
    output hfs_snapshot_t        snap
);

    localparam sum_t SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam sum_t SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    sum_t                sums_reg [3];
    sum_t                sums_next [3];
    logic                overflow_reg;
    logic                snap_valid_reg;
    sum_t                snap_sum_reg [3];
    logic                snap_overflow_reg;
    sum_t                selected;
    sum_t                addend;
    logic [SUM_WIDTH:0]  wide;
    sum_t                clamped;
    logic                hit;

    assign stage_take = stage.valid && (!stage.last || !snap_valid_reg || snap_take);

    always_comb
    begin
        case (stage.phase)
            PHASE_0: selected = sums_reg[0];
            PHASE_1: selected = sums_reg[1];
            default: selected = sums_reg[2];
        endcase
    end

    assign addend = SUM_WIDTH'(stage.value);
    assign wide   = {selected[SUM_WIDTH-1], selected} + {addend[SUM_WIDTH-1], addend};
    assign hit    = stage.add_en && (wide[SUM_WIDTH] != wide[SUM_WIDTH-1]);

    always_comb
    begin
        if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1])
        begin
            clamped = wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            clamped = sum_t'(wide[SUM_WIDTH-1:0]);
        end
        for (int p = 0; p < 3; p++)
        begin
            if (stage.add_en && (stage.phase == phase_t'(p)))
            begin
                sums_next[p] = clamped;
            end
            else
            begin
                sums_next[p] = sums_reg[p];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < 3; p++)
            begin
                sums_reg[p] <= '0;
            end
            overflow_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (stage_take)
            begin
                if (stage.last)
                begin
                    for (int p = 0; p < 3; p++)
                    begin
                        sums_reg[p] <= '0;
                    end
                    overflow_reg <= 1'b0;
                end
                else
                begin
                    for (int p = 0; p < 3; p++)
                    begin
                        sums_reg[p] <= sums_next[p];
                    end
                    overflow_reg <= overflow_reg || hit;
                end
            end
            if (stage_take && stage.last)
            begin
                snap_valid_reg <= 1'b1;
            end
            else if (snap_take)
            begin
                snap_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_take && stage.last)
        begin
            for (int p = 0; p < 3; p++)
            begin
                snap_sum_reg[p] <= sums_next[p];
            end
            snap_overflow_reg <= overflow_reg || hit;
        end
    end

    assign snap.valid    = snap_valid_reg;
    assign snap.sum_0    = snap_sum_reg[0];
    assign snap.sum_1    = snap_sum_reg[1];
    assign snap.sum_2    = snap_sum_reg[2];
    assign snap.overflow = snap_overflow_reg;

endmodule
`default_nettype wire

### hw/rtl/hfs_out.sv
// Selection of the largest phase sum into the result register.
`default_nettype none
module hfs_out
    import hfs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hfs_snapshot_t snap,
    output logic               snap_take,
    output logic               score_valid,
    input  wire logic          score_ready,
    output hfs_out_t           score
);

    logic     valid_reg;
    hfs_out_t score_reg;
    sum_t     best_01;
    sum_t     best;

    assign snap_take = snap.valid && (!valid_reg || score_ready);
    assign best_01   = (snap.sum_1 > snap.sum_0) ? snap.sum_1 : snap.sum_0;
    assign best      = (snap.sum_2 > best_01) ? snap.sum_2 : best_01;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (snap_take)
        begin
            valid_reg <= 1'b1;
        end
        else if (score_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            score_reg.window_score <= SCORE_WIDTH'(best);
            score_reg.saturated    <= snap.overflow;
        end
    end

    assign score_valid = valid_reg;
    assign score       = score_reg;

endmodule
`default_nettype wire

### hw/rtl/hexamer_frame_score_unit.sv
// The last base goes through the read stage and the snapshot register into the score register.
// Throughput: one word per cycle, table writes and bases alike, set by the single
// table read port and the one saturating add per base; a waiting score stalls input
// only when the snapshot is also full and a further window end reaches the read stage.
// Reset clears the strand setting, the window counters, the phase sums and all valid flags;
// the log-ratio table is not cleared and must be loaded before it is read.
`default_nettype none
module hexamer_frame_score_unit
    import hfs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_write_enable,
    input  wire logic     cfg_write_data,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  wire hfs_in_t  item,
    output logic          score_valid,
    input  wire logic     score_ready,
    output hfs_out_t      score
);

    hfs_base_stage_t stage;
    logic            stage_take;
    hfs_snapshot_t   snap;
    logic            snap_take;

    hfs_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .item             (item),
        .stage_take       (stage_take),
        .stage            (stage)
    );

    hfs_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .stage_take (stage_take),
        .snap_take  (snap_take),
        .snap       (snap)
    );

    hfs_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .snap        (snap),
        .snap_take   (snap_take),
        .score_valid (score_valid),
        .score_ready (score_ready),
        .score       (score)
    );

`ifndef SYNTHESIS
    // An accepted base always lands in the table read stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && (item.mode == MODE_BASE)) |=> stage.valid)
        else $error("accepted base did not reach the read stage");

    // A window end that cannot leave the read stage must hold off new words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage.valid && !stage_take) |-> !item_ready)
        else $error("input taken while the read stage is stalled");

    // A snapshot is kept while the score register is full and not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (snap.valid && score_valid && !score_ready) |=> snap.valid)
        else $error("snapshot lost while the score word was stalled");
`endif

endmodule
`default_nettype wire

### tb/hexamer_frame_score_unit_tb.sv
// Self-checking testbench that streams table loads and DNA windows and checks every score word.
`timescale 1ns / 1ps
module hexamer_frame_score_unit_tb;
    import hfs_pkg::*;

    localparam longint SUM_MAX = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_write_enable = 1'b0;
    logic     cfg_write_data = 1'b0;
    logic     item_valid = 1'b0;
    logic     item_ready;
    hfs_in_t  item = '0;
    logic     score_valid;
    logic     score_ready = 1'b0;
    hfs_out_t score;

    hexamer_frame_score_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .item             (item),
        .score_valid      (score_valid),
        .score_ready      (score_ready),
        .score            (score)
    );

    // Shadow copy of the scoring state.
    table_value_t   ratio_mem [TABLE_ENTRIES];
    bit             ratio_loaded [TABLE_ENTRIES];
    hexamer_index_t hex_window = '0;
    logic [2:0]     seen_count = '0;
    phase_t         frame_pos = PHASE_0;
    sum_t           phase_acc [3] = '{default: '0};
    bit             clamp_seen = 1'b0;
    bit             strand_rev = 1'b0;

    hfs_out_t expected_scores [$];
    int       mismatch_count = 0;
    int       words_sent = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_request = 0;
    int       hold_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("hexamer_frame_score_unit: mismatch");
        $finish;
    end

    function automatic logic [1:0] code_nucleotide(logic [7:0] ch, bit rev);
        logic [1:0] c;
        case (ch)
            CHAR_A:  c = 2'd0;
            CHAR_C:  c = 2'd1;
            CHAR_G:  c = 2'd2;
            CHAR_T:  c = 2'd3;
            default: return 2'd1;
        endcase
        return rev ? 2'd3 - c : c;
    endfunction

    task automatic score_word(hfs_in_t w);
        logic [1:0] code;
        phase_t     phase;
        longint     s;
        sum_t       best;
        hfs_out_t   r;
        if (w.mode == MODE_TABLE)
        begin
            ratio_mem[w.table_address] = w.table_value;
            ratio_loaded[w.table_address] = 1'b1;
            return;
        end
        code = code_nucleotide(w.base, strand_rev);
        phase = (frame_pos == PHASE_2) ? PHASE_0 : frame_pos + 2'd1;
        hex_window = {hex_window[ADDR_WIDTH-3:0], code};
        if (seen_count < HEXAMER_BASES)
            seen_count++;
        if (seen_count >= HEXAMER_BASES)
        begin
            s = longint'(phase_acc[phase]) + longint'(ratio_mem[hex_window]);
            if (s > SUM_MAX)
            begin
                s = SUM_MAX;
                clamp_seen = 1'b1;
            end
            else if (s < SUM_MIN)
            begin
                s = SUM_MIN;
                clamp_seen = 1'b1;
            end
            phase_acc[phase] = sum_t'(s);
        end
        frame_pos = phase;
        if (w.last)
        begin
            best = phase_acc[0];
            if (phase_acc[1] > best)
                best = phase_acc[1];
            if (phase_acc[2] > best)
                best = phase_acc[2];
            r.window_score = best;
            r.saturated = clamp_seen;
            expected_scores.push_back(r);
            hex_window = '0;
            seen_count = '0;
            frame_pos = PHASE_0;
            phase_acc = '{default: '0};
            clamp_seen = 1'b0;
        end
    endtask

    task automatic send_word(hfs_in_t w);
        if (send_idle_pct > 0)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        score_word(w);
        words_sent++;
    endtask

    task automatic send_table_write(hexamer_index_t addr, table_value_t value);
        hfs_in_t w;
        w.mode = MODE_TABLE;
        w.table_address = addr;
        w.table_value = value;
        w.base = 8'($urandom);
        w.last = 1'($urandom);
        send_word(w);
    endtask

    function automatic table_value_t random_ratio();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return table_value_t'($signed($urandom_range(4095)) - 2048);
            default: return table_value_t'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] random_nucleotide();
        if ($urandom_range(99) < 12)
            return 8'($urandom);
        case ($urandom_range(3))
            0:       return CHAR_A;
            1:       return CHAR_C;
            2:       return CHAR_G;
            default: return CHAR_T;
        endcase
    endfunction

    // A hexamer never enters a phase sum before its table entry has been loaded.
    task automatic send_base(logic [7:0] ch, bit is_last);
        hexamer_index_t next_index;
        hfs_in_t        w;
        next_index = {hex_window[ADDR_WIDTH-3:0], code_nucleotide(ch, strand_rev)};
        if (seen_count >= HEXAMER_BASES - 3'd1 && !ratio_loaded[next_index])
            send_table_write(next_index, random_ratio());
        w.mode = MODE_BASE;
        w.table_address = 12'($urandom);
        w.table_value = 16'($urandom);
        w.base = ch;
        w.last = is_last;
        send_word(w);
    endtask

    task automatic send_window(int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 5)
                send_table_write(12'($urandom), random_ratio());
            send_base(random_nucleotide(), i == len - 1);
        end
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_strand(bit rev);
        wait_idle();
        cfg_write_enable <= 1'b1;
        cfg_write_data <= rev;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        strand_rev = rev;
    endtask

    always @(posedge clk)
    begin
        hfs_out_t want;
        if (rst_n && score_valid && score_ready)
        begin
            if (expected_scores.size() == 0)
            begin
                $error("score word with no expected score: window_score %0d saturated %0d",
                       score.window_score, score.saturated);
                mismatch_count++;
            end
            else
            begin
                want = expected_scores.pop_front();
                if (score.window_score !== want.window_score)
                begin
                    $error("window_score expected %0d actual %0d",
                           want.window_score, score.window_score);
                    mismatch_count++;
                end
                if (score.saturated !== want.saturated)
                begin
                    $error("saturated expected %0d actual %0d",
                           want.saturated, score.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
            hold_left--;
        score_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_directed_cases();
        logic [7:0] odd_bytes [6] = '{8'h00, 8'hFF, 8'h43, 8'h78, 8'h80, CHAR_C};
        send_base(CHAR_A, 1'b1);
        send_base(CHAR_A, 1'b0);
        send_base(CHAR_C, 1'b0);
        send_base(CHAR_G, 1'b0);
        send_base(CHAR_T, 1'b0);
        send_base(CHAR_G, 1'b1);
        send_table_write(12'h000, 16'sh7FFF);
        send_table_write(12'hFFF, 16'sh8000);
        for (int i = 0; i < 7; i++)
            send_base(CHAR_A, i == 6);
        for (int i = 0; i < 6; i++)
            send_base(odd_bytes[i], i == 5);
        for (int i = 0; i < 6; i++)
            send_base(CHAR_T, i == 5);
        wait_idle();
    endtask

    task automatic test_strand_switching();
        set_strand(1'b1);
        send_window(12);
        for (int i = 0; i < 4; i++)
            send_base(random_nucleotide(), 1'b0);
        set_strand(1'b0);
        for (int i = 0; i < 6; i++)
            send_base(random_nucleotide(), i == 5);
        for (int i = 0; i < 5; i++)
            send_base(random_nucleotide(), 1'b0);
        set_strand(1'b1);
        for (int i = 0; i < 5; i++)
            send_base(random_nucleotide(), i == 4);
        set_strand(1'b0);
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 250;
        for (int i = 0; i < 40; i++)
            send_window(2);
        wait_idle();
    endtask

    task automatic test_random_windows(int send_pct, int recv_pct, int budget);
        int start;
        int len;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        start = words_sent;
        while (words_sent - start < budget)
        begin
            case ($urandom_range(19))
                0, 1:    len = $urandom_range(5, 1);
                2:       len = $urandom_range(120, 60);
                default: len = $urandom_range(40, 6);
            endcase
            send_window(len);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_strand_switching();
        test_output_backpressure();
        test_random_windows(0, 0, 265);
        set_strand(1'b1);
        test_random_windows(67, 0, 265);
        set_strand(1'b0);
        test_random_windows(0, 67, 265);
        set_strand(1'b1);
        test_random_windows(28, 28, 265);
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("hexamer_frame_score_unit: match");
        else
            $display("hexamer_frame_score_unit: mismatch");
        $finish;
    end

endmodule
